// ===== hdl/fdzs_pkg.sv =====
// Shared types, constants and z-order helpers for the first-difference z-scan locator.
// No dependencies; every other file refers to this package by scoped names.
package fdzs_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int UNIT_SIZE  = 64;

    localparam int COORD_BITS    = 12;
    localparam int DIM_BITS      = 13;
    localparam int COLOR_BITS    = 8;
    localparam int PART_BITS     = 8;
    localparam int UNIT_IDX_BITS = 12;
    localparam int UNIT_BITS     = $clog2(UNIT_SIZE);
    localparam int ZLEVELS       = UNIT_BITS - 2;
    localparam int Z_BITS        = 2 * ZLEVELS;
    localparam int KEY_BITS      = UNIT_IDX_BITS + Z_BITS;
    localparam int UA_BITS       = $clog2(MAX_WIDTH / UNIT_SIZE) + 1;
    localparam int ROW_BITS      = COORD_BITS - UNIT_BITS;
    localparam int PROD_BITS     = ROW_BITS + UA_BITS;
    localparam int STEP_BITS     = $clog2(UNIT_IDX_BITS);
    localparam int OY_BITS       = UNIT_IDX_BITS + UNIT_BITS;
    localparam int OX_BITS       = UA_BITS + UNIT_BITS;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [COLOR_BITS-1:0] GRAY_LEVEL = COLOR_BITS'(130);

    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MARK_MODE    = 2'd2;

    typedef struct packed {
        logic [DIM_BITS-1:0] frame_width;
        logic [DIM_BITS-1:0] frame_height;
        logic                mark_mode;
    } cfg_t;

    // Per-frame outcome handed from the front end to the decoder.
    typedef struct packed {
        logic                found;
        logic [KEY_BITS-1:0] key;
    } frame_result_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_COUNT,
        BK_OUTPUT
    } back_state_t;

    function automatic logic [DIM_BITS-1:0] eff_width(input logic [DIM_BITS-1:0] w);
        return (w > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : w;
    endfunction

    function automatic logic [DIM_BITS-1:0] eff_height(input logic [DIM_BITS-1:0] h);
        return (h > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : h;
    endfunction

    // Units per row, at least one.
    function automatic logic [UA_BITS-1:0] units_across(input logic [DIM_BITS-1:0] w_eff);
        logic [DIM_BITS:0]    sum;
        logic [UA_BITS-1:0]   ua;
        sum = {1'b0, w_eff} + (DIM_BITS+1)'(UNIT_SIZE - 1);
        ua  = UA_BITS'(sum >> UNIT_BITS);
        if (ua == '0) begin
            ua = UA_BITS'(1);
        end
        return ua;
    endfunction

    function automatic logic [Z_BITS-1:0] z_interleave(input logic [ZLEVELS-1:0] bx,
                                                       input logic [ZLEVELS-1:0] by);
        logic [Z_BITS-1:0] z;
        z = '0;
        for (int i = 0; i < ZLEVELS; i++) begin
            z[2*i]   = bx[i];
            z[2*i+1] = by[i];
        end
        return z;
    endfunction

    function automatic logic [ZLEVELS-1:0] z_col(input logic [Z_BITS-1:0] z);
        logic [ZLEVELS-1:0] c;
        for (int i = 0; i < ZLEVELS; i++) begin
            c[i] = z[2*i];
        end
        return c;
    endfunction

    function automatic logic [ZLEVELS-1:0] z_row(input logic [Z_BITS-1:0] z);
        logic [ZLEVELS-1:0] r;
        for (int i = 0; i < ZLEVELS; i++) begin
            r[i] = z[2*i+1];
        end
        return r;
    endfunction

endpackage

// ===== hdl/first_difference_z_scan_locator_core.sv =====
// Top level of the first-difference z-scan locator: config registers, front end,
// result queue and decoder. Depends on fdzs_pkg, fdzs_front, fdzs_fifo, fdzs_back.
//
//  group   direction  carries
//  s_*     in         one pixel word per handshake; tlast marks the frame's last pixel
//  m_*     out        one result word per frame; tuser is the found flag
//  cfg_*   in         register writes, index 0 width, 1 height, 2 mark mode
//
// Pixels are taken one per cycle; the front end has two stages (key, then minimum).
// The decoder takes a frame result with nothing differing straight to output; else it runs
// the divider and then the part-count sweep up to z, the block's z index (up to 255),
// before it shows. Reset is synchronous, active low; no clearing pass.
// Pixel input stalls only when two frame results wait in the queue.
module first_difference_z_scan_locator_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // pixel_x[11:0], pixel_y[23:12], red[31:24], green[39:32], blue[47:40]
    input  logic [47:0]                           s_tdata,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // unit_index[11:0], first_x[23:12], first_y[35:24], part_index[43:36], zeros above
    output logic [47:0]                           m_tdata,
    // found[0]
    output logic                                  m_tuser,
    input  logic                                  cfg_wr_en,
    input  logic [fdzs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [fdzs_pkg::DIM_BITS-1:0]         cfg_wdata
);

    fdzs_pkg::cfg_t                         cfg_reg;
    fdzs_pkg::frame_result_t                front_res;
    fdzs_pkg::frame_result_t                queue_res;
    logic                                   front_res_valid;
    logic                                   front_res_ready;
    logic                                   queue_valid;
    logic                                   queue_ready;
    logic [fdzs_pkg::UNIT_IDX_BITS-1:0]     unit_index;
    logic [fdzs_pkg::COORD_BITS-1:0]        first_x;
    logic [fdzs_pkg::COORD_BITS-1:0]        first_y;
    logic [fdzs_pkg::PART_BITS-1:0]         part_index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= fdzs_pkg::DIM_BITS'(1920);
            cfg_reg.frame_height <= fdzs_pkg::DIM_BITS'(1080);
            cfg_reg.mark_mode    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                fdzs_pkg::REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_wdata;
                fdzs_pkg::REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_wdata;
                fdzs_pkg::REG_MARK_MODE:    cfg_reg.mark_mode    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    fdzs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .pixel_x   (s_tdata[11:0]),
        .pixel_y   (s_tdata[23:12]),
        .red       (s_tdata[31:24]),
        .green     (s_tdata[39:32]),
        .blue      (s_tdata[47:40]),
        .frame_end (s_tlast),
        .res_valid (front_res_valid),
        .res_ready (front_res_ready),
        .res       (front_res)
    );

    fdzs_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_res_valid),
        .in_ready  (front_res_ready),
        .in_data   (front_res),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_data  (queue_res)
    );

    fdzs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (queue_valid),
        .in_ready   (queue_ready),
        .in_data    (queue_res),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .found      (m_tuser),
        .unit_index (unit_index),
        .first_x    (first_x),
        .first_y    (first_y),
        .part_index (part_index)
    );

    assign m_tdata = {4'b0000, part_index, first_y, first_x, unit_index};

endmodule

// ===== hdl/fdzs_front.sv =====
// Front end: classifies each pixel, forms its (unit, z) key and keeps the frame minimum.
// Depends on fdzs_pkg.
module fdzs_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  fdzs_pkg::cfg_t                        cfg,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [fdzs_pkg::COORD_BITS-1:0]       pixel_x,
    input  logic [fdzs_pkg::COORD_BITS-1:0]       pixel_y,
    input  logic [fdzs_pkg::COLOR_BITS-1:0]       red,
    input  logic [fdzs_pkg::COLOR_BITS-1:0]       green,
    input  logic [fdzs_pkg::COLOR_BITS-1:0]       blue,
    input  logic                                  frame_end,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output fdzs_pkg::frame_result_t               res
);

    logic [fdzs_pkg::DIM_BITS-1:0]      w_eff;
    logic [fdzs_pkg::DIM_BITS-1:0]      h_eff;
    logic [fdzs_pkg::UA_BITS-1:0]       ua;
    logic                               differs;
    logic                               in_pic;
    logic [fdzs_pkg::PROD_BITS-1:0]     unit_sum;
    logic [fdzs_pkg::KEY_BITS-1:0]      key;
    logic                               accept;

    logic                               st1_valid_reg;
    logic                               st1_hit_reg;
    logic                               st1_last_reg;
    logic [fdzs_pkg::KEY_BITS-1:0]      st1_key_reg;
    logic                               st1_go;

    logic                               any_found_reg;
    logic [fdzs_pkg::KEY_BITS-1:0]      best_key_reg;
    logic                               take;
    logic                               merged_found;
    logic [fdzs_pkg::KEY_BITS-1:0]      merged_key;

    always_comb begin
        w_eff = fdzs_pkg::eff_width(cfg.frame_width);
        h_eff = fdzs_pkg::eff_height(cfg.frame_height);
        ua    = fdzs_pkg::units_across(w_eff);
        if (cfg.mark_mode) begin
            differs = (red != '0) || (green != '0) || (blue != '0);
        end else begin
            differs = (red != fdzs_pkg::GRAY_LEVEL) || (green != fdzs_pkg::GRAY_LEVEL) ||
                      (blue != fdzs_pkg::GRAY_LEVEL);
        end
        in_pic   = ({1'b0, pixel_x} < w_eff) && ({1'b0, pixel_y} < h_eff);
        unit_sum = fdzs_pkg::PROD_BITS'(pixel_y[fdzs_pkg::COORD_BITS-1:fdzs_pkg::UNIT_BITS])
                 * fdzs_pkg::PROD_BITS'(ua)
                 + fdzs_pkg::PROD_BITS'(pixel_x[fdzs_pkg::COORD_BITS-1:fdzs_pkg::UNIT_BITS]);
        key = {unit_sum[fdzs_pkg::UNIT_IDX_BITS-1:0],
               fdzs_pkg::z_interleave(pixel_x[fdzs_pkg::UNIT_BITS-1:2],
                                      pixel_y[fdzs_pkg::UNIT_BITS-1:2])};
    end

    // A frame end can only leave stage 1 when the queue has room.
    assign st1_go  = st1_valid_reg && (!st1_last_reg || res_ready);
    assign s_ready = !st1_valid_reg || st1_go;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_hit_reg  <= differs && in_pic;
            st1_last_reg <= frame_end;
            st1_key_reg  <= key;
        end
    end

    always_comb begin
        take         = st1_hit_reg && (!any_found_reg || (st1_key_reg < best_key_reg));
        merged_found = any_found_reg || st1_hit_reg;
        merged_key   = take ? st1_key_reg : best_key_reg;
    end

    assign res_valid = st1_valid_reg && st1_last_reg;
    assign res.found = merged_found;
    assign res.key   = merged_key;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_found_reg <= 1'b0;
            best_key_reg  <= '1;
        end else if (st1_go) begin
            if (st1_last_reg) begin
                any_found_reg <= 1'b0;
                best_key_reg  <= '1;
            end else begin
                any_found_reg <= merged_found;
                best_key_reg  <= merged_key;
            end
        end
    end

    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_go && st1_last_reg |=> !any_found_reg)
        else $error("minimum not cleared after frame end");

    a_found_has_key: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_go && !st1_last_reg && st1_hit_reg |=> any_found_reg)
        else $error("differing pixel did not set found");

endmodule

// ===== hdl/fdzs_fifo.sv =====
// Short queue of per-frame results between the front end and the decoder.
// Depends on fdzs_pkg.
module fdzs_fifo (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  fdzs_pkg::frame_result_t   in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output fdzs_pkg::frame_result_t   out_data
);

    fdzs_pkg::frame_result_t              entry_reg [fdzs_pkg::QUEUE_DEPTH];
    logic [fdzs_pkg::QPTR_BITS-1:0]       wr_ptr_reg;
    logic [fdzs_pkg::QPTR_BITS-1:0]       rd_ptr_reg;
    logic [fdzs_pkg::QPTR_BITS:0]         count_reg;
    logic                                 push;
    logic                                 pop;

    assign in_ready  = (count_reg != (fdzs_pkg::QPTR_BITS+1)'(fdzs_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (fdzs_pkg::QPTR_BITS+1)'(fdzs_pkg::QUEUE_DEPTH))
        else $error("queue overflow");

endmodule

// ===== hdl/fdzs_back.sv =====
// Back end: decodes a frame's best key into unit origin, block corner and part index.
// Uses a restoring divider for the unit row/column and a z-order sweep for the count.
// Depends on fdzs_pkg.
module fdzs_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  fdzs_pkg::cfg_t                       cfg,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  fdzs_pkg::frame_result_t              in_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 found,
    output logic [fdzs_pkg::UNIT_IDX_BITS-1:0]   unit_index,
    output logic [fdzs_pkg::COORD_BITS-1:0]      first_x,
    output logic [fdzs_pkg::COORD_BITS-1:0]      first_y,
    output logic [fdzs_pkg::PART_BITS-1:0]       part_index
);

    fdzs_pkg::back_state_t                 state_reg, state_next;
    logic                                  found_reg, found_next;
    logic [fdzs_pkg::KEY_BITS-1:0]         key_reg, key_next;
    logic [fdzs_pkg::UNIT_IDX_BITS-1:0]    quo_reg, quo_next;
    logic [fdzs_pkg::UA_BITS-1:0]          rem_reg, rem_next;
    logic [fdzs_pkg::STEP_BITS-1:0]        step_reg, step_next;
    logic [fdzs_pkg::Z_BITS-1:0]           cnt_reg, cnt_next;
    logic [fdzs_pkg::PART_BITS-1:0]        parts_reg, parts_next;
    logic [fdzs_pkg::COORD_BITS-1:0]       x_reg, x_next;
    logic [fdzs_pkg::COORD_BITS-1:0]       y_reg, y_next;

    logic [fdzs_pkg::DIM_BITS-1:0]         w_eff;
    logic [fdzs_pkg::DIM_BITS-1:0]         h_eff;
    logic [fdzs_pkg::UA_BITS-1:0]          ua;
    logic [fdzs_pkg::UA_BITS:0]            trial;
    logic                                  ge;
    logic [fdzs_pkg::Z_BITS-1:0]           z;
    logic [fdzs_pkg::OX_BITS-1:0]          ox;
    logic [fdzs_pkg::OY_BITS-1:0]          oy;
    logic [fdzs_pkg::OX_BITS-1:0]          cx_pos;
    logic [fdzs_pkg::OY_BITS-1:0]          cy_pos;
    logic [fdzs_pkg::OX_BITS-1:0]          bx_pos;
    logic [fdzs_pkg::OY_BITS-1:0]          by_pos;
    logic                                  inside_pic;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fdzs_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg <= found_next;
        key_reg   <= key_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
        cnt_reg   <= cnt_next;
        parts_reg <= parts_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
    end

    always_comb begin
        w_eff = fdzs_pkg::eff_width(cfg.frame_width);
        h_eff = fdzs_pkg::eff_height(cfg.frame_height);
        ua    = fdzs_pkg::units_across(w_eff);

        // one restoring-division step on the unit index
        trial = {rem_reg, quo_reg[fdzs_pkg::UNIT_IDX_BITS-1]};
        ge    = (trial >= {1'b0, ua});

        z      = key_reg[fdzs_pkg::Z_BITS-1:0];
        ox     = fdzs_pkg::OX_BITS'({rem_reg, {fdzs_pkg::UNIT_BITS{1'b0}}});
        oy     = {quo_reg, {fdzs_pkg::UNIT_BITS{1'b0}}};
        cx_pos = ox + fdzs_pkg::OX_BITS'({fdzs_pkg::z_col(cnt_reg), 2'b00});
        cy_pos = oy + fdzs_pkg::OY_BITS'({fdzs_pkg::z_row(cnt_reg), 2'b00});
        bx_pos = ox + fdzs_pkg::OX_BITS'({fdzs_pkg::z_col(z), 2'b00});
        by_pos = oy + fdzs_pkg::OY_BITS'({fdzs_pkg::z_row(z), 2'b00});
        inside_pic = (fdzs_pkg::DIM_BITS'(cx_pos) < w_eff) &&
                     (cy_pos < fdzs_pkg::OY_BITS'(h_eff));

        state_next = state_reg;
        found_next = found_reg;
        key_next   = key_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        parts_next = parts_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        in_ready   = 1'b0;
        m_valid    = 1'b0;

        case (state_reg)
            fdzs_pkg::BK_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    found_next = in_data.found;
                    key_next   = in_data.found ? in_data.key : '0;
                    quo_next   = in_data.key[fdzs_pkg::KEY_BITS-1:fdzs_pkg::Z_BITS];
                    rem_next   = '0;
                    step_next  = '0;
                    cnt_next   = '0;
                    parts_next = '0;
                    x_next     = '0;
                    y_next     = '0;
                    state_next = in_data.found ? fdzs_pkg::BK_DIVIDE : fdzs_pkg::BK_OUTPUT;
                end
            end
            fdzs_pkg::BK_DIVIDE: begin
                quo_next = {quo_reg[fdzs_pkg::UNIT_IDX_BITS-2:0], ge};
                rem_next = ge ? fdzs_pkg::UA_BITS'(trial - {1'b0, ua})
                              : trial[fdzs_pkg::UA_BITS-1:0];
                if (step_reg == fdzs_pkg::STEP_BITS'(fdzs_pkg::UNIT_IDX_BITS - 1)) begin
                    state_next = fdzs_pkg::BK_COUNT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            fdzs_pkg::BK_COUNT: begin
                if (cnt_reg == z) begin
                    x_next     = bx_pos[fdzs_pkg::COORD_BITS-1:0];
                    y_next     = by_pos[fdzs_pkg::COORD_BITS-1:0];
                    state_next = fdzs_pkg::BK_OUTPUT;
                end else begin
                    if (inside_pic) begin
                        parts_next = parts_reg + 1'b1;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            fdzs_pkg::BK_OUTPUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = fdzs_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = fdzs_pkg::BK_IDLE;
            end
        endcase
    end

    assign found      = found_reg;
    assign unit_index = key_reg[fdzs_pkg::KEY_BITS-1:fdzs_pkg::Z_BITS];
    assign first_x    = x_reg;
    assign first_y    = y_reg;
    assign part_index = parts_reg;

    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == fdzs_pkg::BK_COUNT |-> cnt_reg <= z)
        else $error("z sweep ran past the found block");

    a_parts_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == fdzs_pkg::BK_COUNT || state_reg == fdzs_pkg::BK_OUTPUT
        |-> parts_reg <= cnt_reg)
        else $error("part count exceeds blocks swept");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !found |-> unit_index == '0 && first_x == '0 && first_y == '0 &&
                              part_index == '0)
        else $error("result without difference is not cleared");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for first_difference_z_scan_locator_core: random pixel frames with gaps,
// a per-frame prediction of the first differing 4x4 block in z-scan order, and checks.
// Depends on fdzs_pkg and the core RTL; nothing else.

typedef struct packed {
    logic        found;
    logic [11:0] unit_index;
    logic [11:0] first_x;
    logic [11:0] first_y;
    logic [7:0]  part_index;
} frame_report_t;

class z_scan_tracker;
    localparam int UNIT    = fdzs_pkg::UNIT_SIZE;
    localparam int Z_DEPTH = $clog2(UNIT) - 2;
    localparam int Z_COUNT = 1 << (2 * Z_DEPTH);

    logic [12:0]   width_reg;
    logic [12:0]   height_reg;
    logic          mark_reg;
    int unsigned   best_key;
    bit            any_found;
    frame_report_t reports_due[$];
    int            mismatches;

    function new();
        width_reg  = 13'd1920;
        height_reg = 13'd1080;
        mark_reg   = 1'b0;
        best_key   = 32'h000F_FFFF;
        any_found  = 1'b0;
        mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [12:0] value);
        case (index)
            fdzs_pkg::REG_FRAME_WIDTH:  width_reg  = value;
            fdzs_pkg::REG_FRAME_HEIGHT: height_reg = value;
            fdzs_pkg::REG_MARK_MODE:    mark_reg   = value[0];
            default: ;
        endcase
    endfunction

    function int unsigned pic_width();
        return (width_reg > fdzs_pkg::MAX_WIDTH) ? fdzs_pkg::MAX_WIDTH : width_reg;
    endfunction

    function int unsigned pic_height();
        return (height_reg > fdzs_pkg::MAX_HEIGHT) ? fdzs_pkg::MAX_HEIGHT : height_reg;
    endfunction

    // column from the even bits, row from the odd bits
    function void z_split(int unsigned z, output int unsigned bx, output int unsigned by);
        bx = 0;
        by = 0;
        for (int i = 0; i < Z_DEPTH; i++) begin
            bx |= ((z >> (2 * i)) & 1) << i;
            by |= ((z >> (2 * i + 1)) & 1) << i;
        end
    endfunction

    function void take_pixel(logic [11:0] px, logic [11:0] py, logic [7:0] r,
                             logic [7:0] g, logic [7:0] b, logic last);
        int unsigned   w, h, ua, unit, z, key, bx, by, ox, oy, parts, cx, cy;
        bit            differs;
        frame_report_t rep;
        w  = pic_width();
        h  = pic_height();
        ua = (w + UNIT - 1) / UNIT;
        if (ua == 0) begin
            ua = 1;
        end
        if (mark_reg) begin
            differs = (r != 0) || (g != 0) || (b != 0);
        end else begin
            differs = (r != fdzs_pkg::GRAY_LEVEL) || (g != fdzs_pkg::GRAY_LEVEL) ||
                      (b != fdzs_pkg::GRAY_LEVEL);
        end
        if (differs && px < w && py < h) begin
            unit = (py / UNIT) * ua + px / UNIT;
            bx   = (px % UNIT) >> 2;
            by   = (py % UNIT) >> 2;
            z    = 0;
            for (int i = 0; i < Z_DEPTH; i++) begin
                z |= ((bx >> i) & 1) << (2 * i);
                z |= ((by >> i) & 1) << (2 * i + 1);
            end
            key = unit * Z_COUNT + z;
            if (!any_found || key < best_key) begin
                best_key  = key;
                any_found = 1'b1;
            end
        end
        if (!last) begin
            return;
        end
        rep = '0;
        if (any_found) begin
            // decoded with the dimensions in force at the frame's last word
            unit  = best_key / Z_COUNT;
            z     = best_key % Z_COUNT;
            ox    = (unit % ua) * UNIT;
            oy    = (unit / ua) * UNIT;
            parts = 0;
            z_split(z, bx, by);
            for (int unsigned k = 0; k < z; k++) begin
                z_split(k, cx, cy);
                if (ox + 4 * cx < w && oy + 4 * cy < h) begin
                    parts++;
                end
            end
            rep.found      = 1'b1;
            rep.unit_index = 12'(unit);
            rep.first_x    = 12'(ox + 4 * bx);
            rep.first_y    = 12'(oy + 4 * by);
            rep.part_index = 8'(parts);
        end
        reports_due.push_back(rep);
        best_key  = 32'h000F_FFFF;
        any_found = 1'b0;
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function void check_report(logic [47:0] data, logic found_flag);
        frame_report_t want;
        if (reports_due.size() == 0) begin
            $display("%0t: unexpected report: expected none, actual found=%0b data=%h",
                     $time, found_flag, data);
            mismatches++;
            return;
        end
        want = reports_due.pop_front();
        compare("found", want.found, found_flag);
        compare("unit_index", want.unit_index, data[11:0]);
        compare("first_x", want.first_x, data[23:12]);
        compare("first_y", want.first_y, data[35:24]);
        compare("part_index", want.part_index, data[43:36]);
        compare("tdata padding", 0, data[47:44]);
    endfunction
endclass

module testbench;
    localparam logic [1:0] REG_SPARE    = 2'd3;   // decodes to no register
    localparam logic [7:0] GRAY         = fdzs_pkg::GRAY_LEVEL;
    localparam int         DRAIN_CYCLES = 400;    // more than the decoder's worst case
    localparam int         LONG_HOLD    = 1500;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en;
    logic [fdzs_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [fdzs_pkg::DIM_BITS-1:0]       cfg_wdata;

    z_scan_tracker tracker;
    bit            quiet;      // no random gaps on either side
    bit            hold_req;   // one long hold-off on the result side

    first_difference_z_scan_locator_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // worst case is every word ending a frame with the longest decode and stalls
    initial begin
        #40_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin : result_sink
        int wait_cycles;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            wait_cycles = quiet ? 0 : $urandom_range(0, 13);
            if (hold_req) begin
                hold_req    = 1'b0;
                wait_cycles = LONG_HOLD;
            end
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            tracker.check_report(m_tdata, m_tuser);
        end
    end

    task automatic send_pixel(input logic [11:0] px, py, input logic [7:0] r, g, b,
                              input logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r, py, px};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        tracker.take_pixel(px, py, r, g, b, last);
    endtask

    // Wait until every report is in and the pipeline has emptied.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.reports_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [12:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.write_reg(index, value);
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [12:0] w, h, input logic mark);
        write_reg(fdzs_pkg::REG_FRAME_WIDTH, w);
        write_reg(fdzs_pkg::REG_FRAME_HEIGHT, h);
        write_reg(fdzs_pkg::REG_MARK_MODE, {12'd0, mark});
    endtask

    task automatic send_frame(input int count, input int diff_pct);
        int unsigned w, h, span_x, span_y;
        int          k;
        logic [11:0] px, py;
        logic [7:0]  base, r, g, b;
        for (int i = 0; i < count; i++) begin
            w      = tracker.pic_width();
            h      = tracker.pic_height();
            span_x = (w == 0) ? 1 : w;
            span_y = (h == 0) ? 1 : h;
            case ($urandom_range(0, 9))
                0: begin
                    px = 12'($urandom);
                    py = 12'($urandom);
                end
                1: begin
                    // straddle the right and bottom edges
                    px = 12'(w - 4 + $urandom_range(0, 7));
                    py = 12'(h - 4 + $urandom_range(0, 7));
                end
                2, 3, 4: begin
                    // crowd the first units so candidates compete closely
                    px = 12'($urandom_range(0, (span_x < 128 ? span_x : 128) - 1));
                    py = 12'($urandom_range(0, (span_y < 128 ? span_y : 128) - 1));
                end
                default: begin
                    px = 12'($urandom_range(0, span_x - 1));
                    py = 12'($urandom_range(0, span_y - 1));
                end
            endcase
            base = tracker.mark_reg ? 8'd0 : GRAY;
            r = base;
            g = base;
            b = base;
            if ($urandom_range(0, 99) < diff_pct) begin
                case ($urandom_range(0, 2))
                    0: begin
                        r = 8'($urandom);
                        g = 8'($urandom);
                        b = 8'($urandom);
                    end
                    1: begin
                        k = $urandom_range(0, 23);
                        {b, g, r} = {b, g, r} ^ (24'd1 << k);
                    end
                    default: begin
                        // the other mode's background color
                        r = tracker.mark_reg ? GRAY : 8'd0;
                        g = r;
                        b = r;
                    end
                endcase
            end
            send_pixel(px, py, r, g, b, i == count - 1);
        end
    endtask

    task automatic run_phase(input int items);
        int sent, n, pct;
        sent = 0;
        while (sent < items) begin
            quiet = ($urandom_range(0, 4) == 0);
            n     = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
                0:       pct = 0;
                1:       pct = 3;
                2:       pct = 15;
                default: pct = 60;
            endcase
            send_frame(n, pct);
            sent += n;
        end
        quiet = 1'b0;
    endtask

    initial begin : stimulus
        tracker = new();
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= fdzs_pkg::REG_FRAME_WIDTH;
        cfg_wdata <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset dimensions 1920x1080, gray background
        send_pixel(12'd0, 12'd0, GRAY, GRAY, GRAY, 1'b1);
        send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(12'd1919, 12'd1079, 8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(12'd70, 12'd3, GRAY, GRAY, 8'd131, 1'b0);
        send_pixel(12'd60, 12'd60, GRAY, 8'd129, GRAY, 1'b0);
        send_pixel(12'd64, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(12'd8, 12'd4, GRAY, GRAY, GRAY, 1'b1);
        send_pixel(12'd5, 12'd5, GRAY, GRAY, GRAY, 1'b1);

        // width changes mid-frame: judged at 1920, decoded at 1024
        send_pixel(12'd1900, 12'd0, 8'd1, GRAY, GRAY, 1'b0);
        settle();
        write_reg(fdzs_pkg::REG_FRAME_WIDTH, 13'd1024);
        send_pixel(12'd0, 12'd0, GRAY, GRAY, GRAY, 1'b1);
        settle();
        write_reg(fdzs_pkg::REG_MARK_MODE, 13'd1);
        send_pixel(12'd4, 12'd4, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(12'd0, 12'd4, GRAY, GRAY, GRAY, 1'b0);
        send_pixel(12'd4, 12'd0, 8'd0, 8'd0, 8'd1, 1'b0);
        send_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b1);

        // smallest picture
        settle();
        write_reg(REG_SPARE, 13'h1FFF);
        set_config(13'd4, 13'd4, 1'b1);
        send_pixel(12'd3, 12'd3, 8'd255, 8'd0, 8'd0, 1'b0);
        send_pixel(12'd4, 12'd0, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(12'd0, 12'd4, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(12'd3, 12'd0, 8'd0, 8'd128, 8'd0, 1'b1);
        run_phase(120);

        settle();
        set_config(13'd4096, 13'd4096, 1'b0);
        send_pixel(12'd4095, 12'd4095, 8'd0, GRAY, GRAY, 1'b1);
        run_phase(250);

        // oversized dimensions saturate
        settle();
        set_config(13'h1FFF, 13'h1FFF, 1'b1);
        send_pixel(12'd4095, 12'd4095, 8'd1, 8'd0, 8'd0, 1'b1);
        run_phase(200);

        // zero dimensions: nothing is inside the picture
        settle();
        set_config(13'd0, 13'd0, 1'b0);
        run_phase(100);

        settle();
        set_config(13'd100, 13'd60, 1'b1);
        run_phase(250);

        // hold the result side while short frames keep coming, so input backs up
        hold_req = 1'b1;
        quiet    = 1'b1;
        repeat (30) send_frame($urandom_range(1, 2), 100);
        quiet = 1'b0;

        repeat (3) begin
            settle();
            set_config(13'($urandom_range(1, 1024) * 4), 13'($urandom_range(1, 1024) * 4),
                       1'($urandom_range(0, 1)));
            run_phase(220);
        end
        settle();
        set_config(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                   1'($urandom_range(0, 1)));
        run_phase(220);

        settle();
        if (tracker.mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
